// ===== sv/smf_pkg.sv =====
package smf_pkg;

    localparam int RANGE_W    = 16;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_BEAMS  = 3;
    localparam int WIN_TAPS   = 9;
    localparam int WIN_COLS   = 6;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = 4;
    localparam int FIFO_CNT_W = 5;
    localparam int SEEN_W     = 2;

    localparam logic [SEEN_W-1:0] SEEN_FULL = 2'd2;

    typedef logic [RANGE_W-1:0] range_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLAMP_LO   = 2'd0,
        CFG_CLAMP_HI   = 2'd1,
        CFG_BEAM_COUNT = 2'd2
    } cfg_idx_t;

    // one output beam
    typedef struct packed {
        logic   eos;
        range_t range;
    } result_t;

    // per-beam control carried alongside the median network
    typedef struct packed {
        logic   has_prev;
        logic   filt;
        logic   last;
        range_t raw_prev;
        range_t last_sample;
    } side_t;

    // up to two results pushed per beam, first one goes out first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic range_t rmin(input range_t a, input range_t b);
        rmin = (a < b) ? a : b;
    endfunction

    function automatic range_t rmax(input range_t a, input range_t b);
        rmax = (a > b) ? a : b;
    endfunction

    function automatic range_t med3(input range_t a, input range_t b, input range_t c);
        med3 = rmax(rmin(a, b), rmin(rmax(a, b), c));
    endfunction

    // below lo gives lo, otherwise above hi gives hi
    function automatic range_t clamp_range(input range_t x, input range_t lo, input range_t hi);
        if (x < lo) begin
            clamp_range = lo;
        end
        else if (x > hi) begin
            clamp_range = hi;
        end
        else begin
            clamp_range = x;
        end
    endfunction

endpackage

// ===== sv/scan_median_filter_3x3_core.sv =====
// Streaming 3x3 median filter for laser range scans. One raw range sample per
// beam enters on the slave stream; filtered beams leave on the master stream,
// with tlast on the last beam of every scan. From the third scan on, every
// inner beam is the median of the nine samples at beams i-1..i+1 of the
// current scan and the two scans before it, each clamped to the programmable
// lower and upper bounds; first and last beams and the first two scans pass
// raw. Output lags one beam, and the last beam of a scan leaves right after
// the one before it. The block takes one beam per clock while the queue has
// credit: the two earlier scans sit in a single-port-per-side line store (one
// read, one write per cycle) and the median network is four register stages.
// A 16-entry output queue with credit-based flow control keeps the input
// running while results wait on the master side.
// beam_count is taken as at least 3 and at most MAX_BEAMS. The user must
// write configuration only while the block is idle; the block itself does
// not enforce it. After reset the line store holds nothing meaningful until
// the first two scans have passed, and no clearing pass is made.
module scan_median_filter_3x3_core
    import smf_pkg::*;
#(
    parameter int MAX_BEAMS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input beams
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [RANGE_W-1:0]   s_axis_tdata,   // [15:0] range_sample
    // output beams
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [RANGE_W-1:0]   m_axis_tdata,   // [15:0] filtered_range
    output logic                 m_axis_tlast,   // end_of_scan
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data
);

    localparam int POS_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int CNT_W = $clog2(MAX_BEAMS + 1);

    // configuration registers
    range_t               clamp_lo_reg;
    range_t               clamp_hi_reg;
    logic [COUNT_W-1:0]   beam_count_reg;

    // scan position tracking
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic [POS_W-1:0]     pos_cur;
    logic [CNT_W-1:0]     n_eff;
    logic                 last_cur;
    logic                 in_xfer;

    // beam waiting on line store read data
    logic                 s1_vld_reg;
    range_t               s1_sample_reg;
    logic [POS_W-1:0]     s1_pos_reg;
    logic                 s1_last_reg;
    logic                 s1_prev_reg;
    logic                 s1_filt_reg;

    // window columns: [0..2] beam p-2, [3..5] beam p-1 (current, prior, older)
    range_t [WIN_COLS-1:0] win_reg;

    range_t                prior_q;
    range_t                older_q;
    range_t [WIN_TAPS-1:0] taps;
    side_t                 s1_side;

    logic                  med_vld;
    range_t                med_val;
    side_t                 med_side;
    push_t                 push;

    logic [FIFO_CNT_W-1:0] space_reg;
    logic [FIFO_CNT_W-1:0] space_next;
    logic [FIFO_CNT_W-1:0] space_back;
    result_t               out_res;
    logic                  out_xfer;

    // config port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_lo_reg   <= '0;
            clamp_hi_reg   <= '1;
            beam_count_reg <= COUNT_W'(1024);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CLAMP_LO:   clamp_lo_reg   <= cfg_data;
                CFG_CLAMP_HI:   clamp_hi_reg   <= cfg_data;
                CFG_BEAM_COUNT: beam_count_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective scan length, clipped to MIN_BEAMS..MAX_BEAMS
    always_comb
    begin
        if (32'(beam_count_reg) < MIN_BEAMS)
        begin
            n_eff = CNT_W'(MIN_BEAMS);
        end
        else if (32'(beam_count_reg) > MAX_BEAMS)
        begin
            n_eff = CNT_W'(MAX_BEAMS);
        end
        else
        begin
            n_eff = CNT_W'(beam_count_reg);
        end
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign pos_cur  = (32'(pos_reg) >= MAX_BEAMS) ? '0 : pos_reg;
    // a shrink of beam_count mid-scan ends the scan at the next beam
    assign last_cur = (32'(pos_cur) + 32'd1 >= 32'(n_eff));

    always_comb
    begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        if (in_xfer)
        begin
            if (last_cur)
            begin
                pos_next = '0;
                if (seen_reg != SEEN_FULL)
                begin
                    seen_next = seen_reg + SEEN_W'(1);
                end
            end
            else
            begin
                pos_next = pos_cur + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            seen_reg   <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            s1_vld_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= s_axis_tdata;
            s1_pos_reg    <= pos_cur;
            s1_last_reg   <= last_cur;
            s1_prev_reg   <= (pos_cur != '0);
            s1_filt_reg   <= (32'(pos_cur) >= 2) && (seen_reg == SEEN_FULL);
        end
    end

    // two earlier scans: read at accept, write back in the cycle after. Two
    // consecutive beams never share a position, so the write never hits the
    // entry being read in the same cycle.
    smf_line_store #(
        .DEPTH  (MAX_BEAMS),
        .ADDR_W (POS_W)
    ) u_store (
        .clk      (clk),
        .rd_en    (in_xfer),
        .rd_addr  (pos_cur),
        .wr_en    (s1_vld_reg),
        .wr_addr  (s1_pos_reg),
        .wr_prior (s1_sample_reg),
        .wr_older (prior_q),
        .prior_q  (prior_q),
        .older_q  (older_q)
    );

    // slide the window by one column per beam
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_vld_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1_sample_reg;
            win_reg[4] <= prior_q;
            win_reg[5] <= older_q;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_COLS; i++)
        begin
            taps[i] = win_reg[i];
        end
        taps[6] = s1_sample_reg;
        taps[7] = prior_q;
        taps[8] = older_q;

        s1_side.has_prev    = s1_prev_reg;
        s1_side.filt        = s1_filt_reg;
        s1_side.last        = s1_last_reg;
        s1_side.raw_prev    = win_reg[3];
        s1_side.last_sample = s1_sample_reg;
    end

    smf_median9 u_median (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s1_vld_reg),
        .in_taps  (taps),
        .lo_bound (clamp_lo_reg),
        .hi_bound (clamp_hi_reg),
        .in_side  (s1_side),
        .out_vld  (med_vld),
        .out_med  (med_val),
        .out_side (med_side)
    );

    // results of one beam: the beam before it, then the last beam of the scan
    always_comb
    begin
        push.cnt          = {1'b0, med_side.has_prev} + {1'b0, med_side.last};
        push.second.eos   = 1'b1;
        push.second.range = med_side.last_sample;
        if (med_side.has_prev)
        begin
            push.first.eos   = 1'b0;
            push.first.range = med_side.filt ? med_val : med_side.raw_prev;
        end
        else
        begin
            push.first = push.second;
        end
    end

    smf_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_vld (med_vld),
        .push     (push),
        .out_vld  (m_axis_tvalid),
        .out_rdy  (m_axis_tready),
        .out_data (out_res)
    );

    assign m_axis_tdata = out_res.range;
    assign m_axis_tlast = out_res.eos;
    assign out_xfer     = m_axis_tvalid && m_axis_tready;

    // credits: two queue entries held per beam in flight, the unused ones
    // return when the beam reaches the queue, one more per output transfer
    assign space_back = med_vld ? FIFO_CNT_W'(2'd2 - push.cnt) : '0;

    always_comb
    begin
        space_next = space_reg + space_back + FIFO_CNT_W'(out_xfer)
                   - (in_xfer ? FIFO_CNT_W'(2) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg <= FIFO_CNT_W'(FIFO_DEPTH);
        end
        else
        begin
            space_reg <= space_next;
        end
    end

    assign s_axis_tready = (space_reg >= FIFO_CNT_W'(2));

endmodule

// ===== sv/smf_line_store.sv =====
module smf_line_store
    import smf_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  range_t            wr_prior,
    input  range_t            wr_older,
    output range_t            prior_q,
    output range_t            older_q
);

    range_t prior_mem [DEPTH];
    range_t older_mem [DEPTH];
    range_t prior_rd_reg;
    range_t older_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prior_mem[wr_addr] <= wr_prior;
            older_mem[wr_addr] <= wr_older;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            prior_rd_reg <= prior_mem[rd_addr];
            older_rd_reg <= older_mem[rd_addr];
        end
    end

    assign prior_q = prior_rd_reg;
    assign older_q = older_rd_reg;

endmodule

// ===== sv/smf_median9.sv =====
module smf_median9
    import smf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  range_t [WIN_TAPS-1:0]      in_taps,
    input  range_t                     lo_bound,
    input  range_t                     hi_bound,
    input  side_t                      in_side,
    output logic                       out_vld,
    output range_t                     out_med,
    output side_t                      out_side
);

    // clamp, sort rows, column extremes, final median of three
    range_t [WIN_TAPS-1:0] clamp_reg;
    range_t [2:0]          row_lo_reg;
    range_t [2:0]          row_mid_reg;
    range_t [2:0]          row_hi_reg;
    range_t                lo_reg;
    range_t                mid_reg;
    range_t                hi_reg;
    range_t                med_reg;
    logic   [3:0]          vld_reg;
    side_t  [3:0]          side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= {side_reg[2:0], in_side};
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            clamp_reg[i] <= clamp_range(in_taps[i], lo_bound, hi_bound);
        end
        for (int r = 0; r < 3; r++)
        begin
            row_lo_reg[r]  <= rmin(rmin(clamp_reg[3*r], clamp_reg[3*r+1]), clamp_reg[3*r+2]);
            row_mid_reg[r] <= med3(clamp_reg[3*r], clamp_reg[3*r+1], clamp_reg[3*r+2]);
            row_hi_reg[r]  <= rmax(rmax(clamp_reg[3*r], clamp_reg[3*r+1]), clamp_reg[3*r+2]);
        end
        lo_reg  <= rmax(rmax(row_lo_reg[0], row_lo_reg[1]), row_lo_reg[2]);
        mid_reg <= med3(row_mid_reg[0], row_mid_reg[1], row_mid_reg[2]);
        hi_reg  <= rmin(rmin(row_hi_reg[0], row_hi_reg[1]), row_hi_reg[2]);
        med_reg <= med3(lo_reg, mid_reg, hi_reg);
    end

    assign out_vld  = vld_reg[3];
    assign out_med  = med_reg;
    assign out_side = side_reg[3];

endmodule

// ===== sv/smf_out_fifo.sv =====
module smf_out_fifo
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_vld,
    input  push_t   push,
    output logic    out_vld,
    input  logic    out_rdy,
    output result_t out_data
);

    result_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic [FIFO_CNT_W-1:0]  cnt_next;
    logic [1:0]             n_push;
    logic                   pop;

    assign n_push = push_vld ? push.cnt : 2'd0;
    assign pop    = out_vld && out_rdy;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    assign out_vld  = (cnt_reg != '0);
    assign out_data = fifo_mem[rd_ptr_reg];

endmodule

// ===== sv/smf_checker.sv =====
module smf_checker
    import smf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [RANGE_W-1:0]   m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a result shows up only after an input transfer
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_xfer, 6))
        else $error("output appeared without a matching input transfer");

    // with the queue drained and nothing in flight the input side is open
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(in_xfer, 1) && !$past(in_xfer, 2) &&
        !$past(in_xfer, 3) && !$past(in_xfer, 4) && !$past(in_xfer, 5) &&
        !$past(in_xfer, 6) |-> s_axis_tready)
        else $error("input blocked while block is idle");

    // register writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind scan_median_filter_3x3_core smf_checker u_smf_checker (.*);

// ===== tb/tb.sv =====
module tb;
    import smf_pkg::*;

    localparam int MAX_BEAMS     = 1024;
    localparam int SMALL_BEAMS   = 32;      // every count after the opening scans stays at or below
    localparam int OPEN_BEAMS    = 100;
    localparam int RANDOM_BEAMS  = 520;
    localparam int SETTLE_CYCLES = 16;      // pipeline latency plus margin
    localparam int LONG_HOLD     = 300;
    localparam int RUN_LIMIT     = 500000;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE,
        SINK_ALTERNATE
    } sink_mode_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     s_axis_tvalid = 1'b0;
    logic     s_axis_tready;
    range_t   s_axis_tdata = '0;     // [15:0] range_sample
    logic     m_axis_tvalid;
    logic     m_axis_tready = 1'b0;
    range_t   m_axis_tdata;          // [15:0] filtered_range
    logic     m_axis_tlast;          // end_of_scan
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CFG_CLAMP_LO;
    range_t   cfg_data = '0;

    // register copies as the block should hold them
    range_t               range_lo = 16'h0000;
    range_t               range_hi = 16'hFFFF;
    logic [COUNT_W-1:0]   beam_count_q = 11'd1024;

    // line stores and window of the filter as the block should hold them
    range_t      prior_line [MAX_BEAMS];
    range_t      older_line [MAX_BEAMS];
    range_t      win_cols [WIN_COLS] = '{default: '0};
    int unsigned next_beam = 0;
    int unsigned scans_done = 0;

    range_t  samples_todo [$];
    result_t beams_due [$];

    logic       in_taken = 1'b0;
    int         in_count = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         idle_left = 0;
    int         hold_at = 32'h7FFF_FFFF;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    sink_mode_t sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         sink_tick = 0;
    int         sample_mid = 30000;
    int         spread = 20000;

    always #4 clk = ~clk;

    scan_median_filter_3x3_core #(
        .MAX_BEAMS(MAX_BEAMS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // append one sample to the send queue
    function automatic void add_sample(input range_t s);
        samples_todo = {samples_todo, s};
    endfunction

    // append one expected beam to the check queue
    function automatic void add_due(input result_t b);
        beams_due = {beams_due, b};
    endfunction

    // advance the filter by one accepted beam and queue the beams it releases
    function automatic void filter_beam(range_t beam_in);
        int unsigned n;
        int unsigned p;
        range_t      prior;
        range_t      older;
        range_t      val;
        range_t      x;
        range_t      taps [9];
        range_t      sorted [9];
        logic        last;
        int          i;
        int          j;
        result_t     beam;
        n = beam_count_q;
        if (n < MIN_BEAMS)
            n = MIN_BEAMS;
        if (n > MAX_BEAMS)
            n = MAX_BEAMS;
        p = (next_beam >= MAX_BEAMS) ? 0 : next_beam;
        last = (p >= n - 1);
        prior = prior_line[p];
        older = older_line[p];

        // beam p-1 leaves now, filtered only when it is inner and two scans are stored
        if (p >= 1)
        begin
            val = win_cols[3];
            if (p >= 2 && scans_done >= 2)
            begin
                for (i = 0; i < WIN_COLS; i++)
                    taps[i] = win_cols[i];
                taps[6] = beam_in;
                taps[7] = prior;
                taps[8] = older;
                for (i = 0; i < WIN_TAPS; i++)
                begin
                    x = taps[i];
                    if (x < range_lo)
                        x = range_lo;
                    else if (x > range_hi)
                        x = range_hi;
                    j = i;
                    while (j > 0 && sorted[j-1] > x)
                    begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = x;
                end
                val = sorted[4];
            end
            beam.eos = 1'b0;
            beam.range = val;
            add_due(beam);
        end
        // last beam of the scan goes out raw right behind
        if (last)
        begin
            beam.eos = 1'b1;
            beam.range = beam_in;
            add_due(beam);
        end

        for (i = 0; i < 3; i++)
            win_cols[i] = win_cols[i+3];
        win_cols[3] = beam_in;
        win_cols[4] = prior;
        win_cols[5] = older;
        older_line[p] = prior;
        prior_line[p] = beam_in;

        if (last)
        begin
            next_beam = 0;
            if (scans_done < 2)
                scans_done++;
        end
        else
            next_beam = p + 1;
    endfunction

    // half the values clustered around sample_mid, the rest uniform or extremes
    function automatic range_t draw_sample();
        int v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 1) ? 65535 : 0;
            1, 2, 3: v = $urandom_range(0, 65535);
            default:
            begin
                v = $urandom_range(0, 2 * spread);
                v = v + sample_mid - spread;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return range_t'(v);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[RANGE_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CLAMP_LO:   range_lo = val[RANGE_W-1:0];
            CFG_CLAMP_HI:   range_hi = val[RANGE_W-1:0];
            CFG_BEAM_COUNT: beam_count_q = val[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer(input range_t a, input range_t b, input range_t c);
        add_sample(a);
        add_sample(b);
        add_sample(c);
    endtask

    // block idle: nothing left to send, nothing outstanding, pipeline flushed
    task automatic drain();
        do
            @(posedge clk);
        while (samples_todo.size() != 0 || s_axis_tvalid || beams_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of random length, random gaps, one transfer per handshake
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (samples_todo.size() != 0)
            begin
                s_axis_tdata  <= samples_todo.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 23);
                    idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: changing stall pattern, plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && in_count >= hold_at)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left > 0)
                mode_left--;
            else
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            sink_tick++;
            case (sink_mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= sink_tick[0];
            endcase
        end
    end

    // monitor: check output transfers first, then predict from the input transfer
    always @(posedge clk)
    begin
        result_t want;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (beams_due.size() == 0)
            begin
                mismatches++;
                $error("filtered_range: expected none, got %0d (end_of_scan %0b)",
                       m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = beams_due.pop_front();
                if (m_axis_tdata !== want.range)
                begin
                    mismatches++;
                    $error("filtered_range: expected %0d, got %0d", want.range, m_axis_tdata);
                end
                if (m_axis_tlast !== want.eos)
                begin
                    mismatches++;
                    $error("end_of_scan: expected %0b, got %0b", want.eos, m_axis_tlast);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            filter_beam(s_axis_tdata);
            in_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("scan_median_filter_3x3_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int random_total;
        int round;
        int round_len;
        int lo;
        int hi;
        int d;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // opening scan under a count past the maximum, which acts as the maximum
        write_reg(CFG_BEAM_COUNT, 2047);
        add_sample(16'h0000);
        add_sample(16'hFFFF);
        add_sample(16'hAAAA);
        add_sample(16'h5555);
        repeat (OPEN_BEAMS - 4) add_sample(draw_sample());
        drain();
        // shrink mid-scan: the next beam closes the opening scan
        write_reg(CFG_BEAM_COUNT, SMALL_BEAMS);
        add_sample(draw_sample());
        drain();
        // second scan fills every position read from here on
        repeat (SMALL_BEAMS) add_sample(draw_sample());
        drain();

        // count below the minimum acts as three: filtering on the middle beam
        write_reg(CFG_BEAM_COUNT, 0);
        offer(16'd100, 16'd200, 16'd300);
        offer(16'hFFFF, 16'h0000, 16'hFFFF);
        drain();
        write_reg(CFG_CLAMP_LO, 1000);
        write_reg(CFG_CLAMP_HI, 2000);
        offer(16'h0000, 16'hFFFF, 16'd1500);
        drain();
        // crossed bounds
        write_reg(CFG_CLAMP_LO, 50000);
        write_reg(CFG_CLAMP_HI, 10);
        offer(16'd40000, 16'd5, 16'd60000);
        drain();
        write_reg(CFG_BEAM_COUNT, 2);
        write_reg(CFG_CLAMP_LO, 0);
        write_reg(CFG_CLAMP_HI, 0);
        offer(16'h8000, 16'h7FFF, 16'hFFFF);
        drain();
        write_reg(CFG_BEAM_COUNT, 1);
        write_reg(CFG_CLAMP_LO, 65535);
        write_reg(CFG_CLAMP_HI, 65535);
        offer(16'h0001, 16'hFFFE, 16'h1234);
        drain();
        // shrink mid-scan: the next beam closes the scan
        write_reg(CFG_CLAMP_LO, 0);
        write_reg(CFG_CLAMP_HI, 65535);
        write_reg(CFG_BEAM_COUNT, 12);
        offer(16'd7000, 16'd7100, 16'd6900);
        add_sample(16'd7050);
        drain();
        write_reg(CFG_BEAM_COUNT, 3);
        add_sample(16'd7020);
        offer(16'd10, 16'd65000, 16'd30);

        random_total = 0;
        round = 0;
        while (random_total < RANDOM_BEAMS)
        begin
            drain();
            sample_mid = $urandom_range(0, 65535);
            spread = $urandom_range(0, 4) == 0 ? 40000 : $urandom_range(4, 3000);
            if ($urandom_range(0, 1))
                write_reg(CFG_BEAM_COUNT, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 2) : $urandom_range(MIN_BEAMS, SMALL_BEAMS));
            case ($urandom_range(0, 5))
                0:
                begin
                    lo = 0;
                    hi = 65535;
                end
                1, 2:
                begin
                    d = $urandom_range(0, spread);
                    lo = (sample_mid > d) ? sample_mid - d : 0;
                    d = $urandom_range(0, spread);
                    hi = (sample_mid + d > 65535) ? 65535 : sample_mid + d;
                end
                3:
                begin
                    // crossed window around the data
                    d = $urandom_range(1, spread + 1);
                    hi = (sample_mid > d) ? sample_mid - d : 0;
                    lo = (sample_mid + d > 65535) ? 65535 : sample_mid + d;
                end
                4:
                begin
                    lo = $urandom_range(0, 65535);
                    hi = $urandom_range(0, 65535);
                end
                default:
                begin
                    lo = $urandom_range(0, 1) ? 65535 : 0;
                    hi = $urandom_range(0, 1) ? 65535 : 0;
                end
            endcase
            write_reg(CFG_CLAMP_LO, lo);
            write_reg(CFG_CLAMP_HI, hi);
            round_len = $urandom_range(8, 60);
            if (round == 3)
            begin
                // long round: receiver holds off partway through so the input stalls
                round_len = 150;
                hold_at = in_count + 20;
            end
            repeat (round_len) add_sample(draw_sample());
            random_total += round_len;
            round++;
        end
        drain();

        if (mismatches == 0 && beams_due.size() == 0)
            $display("scan_median_filter_3x3_core regression: pass");
        else
            $display("scan_median_filter_3x3_core regression: fail");
        $finish;
    end

endmodule
